// ===== sv/hkr_pkg.sv =====
// hkr_pkg: types, sizes and the pattern match function for the key report encoder
// used by the key cell, the core and the checker; no dependencies
`default_nettype none
package hkr_pkg;

  localparam int KEY_SLOTS     = 6;
  localparam int MATCH_BYTES   = 4;
  localparam int ASCII_ENTRIES = 128;
  localparam int UTF8_ENTRIES  = 128;
  localparam int COMBO_ENTRIES = 32;
  localparam int REPORT_SLOTS  = 6;

  localparam int ASCII_AW = $clog2(ASCII_ENTRIES);
  localparam int UTF8_AW  = $clog2(UTF8_ENTRIES);
  localparam int COMBO_AW = $clog2(COMBO_ENTRIES);
  localparam int SCAN_W   = 11;
  localparam int SLOT_CW  = $clog2(KEY_SLOTS + 1);

  localparam logic [2:0] FN_PRESS_CHAR = 3'd0;
  localparam logic [2:0] FN_TYPE_CHAR  = 3'd1;
  localparam logic [2:0] FN_RELEASE    = 3'd2;
  localparam logic [2:0] FN_PRESS_KEY  = 3'd3;
  localparam logic [2:0] FN_PRESS_MOD  = 3'd4;
  localparam logic [2:0] FN_LOAD_ASCII = 3'd5;
  localparam logic [2:0] FN_LOAD_UTF8  = 3'd6;
  localparam logic [2:0] FN_LOAD_COMBO = 3'd7;

  localparam logic [1:0] CFG_ASCII_COUNT = 2'd0;
  localparam logic [1:0] CFG_UTF8_COUNT  = 2'd1;
  localparam logic [1:0] CFG_COMBO_COUNT = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  char_byte0;
    logic [7:0]  char_byte1;
    logic [7:0]  char_byte2;
    logic [7:0]  char_byte3;
    logic [7:0]  key_code;
    logic [7:0]  modifier_bits;
    logic [6:0]  entry_index;
    logic [63:0] entry_data;
  } in_t;

  typedef struct packed {
    logic       report_valid;
    logic [7:0] report_modifiers;
    logic [7:0] key_slot0;
    logic [7:0] key_slot1;
    logic [7:0] key_slot2;
    logic [7:0] key_slot3;
    logic [7:0] key_slot4;
    logic [7:0] key_slot5;
    logic [1:0] extra_bytes;
    logic       last;
  } out_t;

  // key token handed from cell to cell
  typedef struct packed {
    logic       valid;
    logic [7:0] key;
  } tok_t;

  function automatic logic [2:0] match_len(input logic [31:0] pat, input logic [31:0] chr);
    logic [2:0] n;
    logic       stop;
    logic       bad;
    n    = 3'd0;
    stop = 1'b0;
    bad  = 1'b0;
    for (int j = 0; j < MATCH_BYTES; j++) begin
      if (!stop && !bad) begin
        if (pat[8*j +: 8] == 8'h00) begin
          stop = 1'b1;
        end else if (pat[8*j +: 8] != chr[8*j +: 8]) begin
          bad = 1'b1;
        end else begin
          n = n + 3'd1;
        end
      end
    end
    return bad ? 3'd0 : n;
  endfunction

endpackage
`default_nettype wire

// ===== sv/hkr_ram.sv =====
// hkr_ram: generic single write, single registered read memory
// no dependencies
`default_nettype none
module hkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/hkr_key_cell.sv =====
// hkr_key_cell: one key slot; takes a passing key token when empty, else hands it on
// depends on hkr_pkg
`default_nettype none
module hkr_key_cell (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         clear,
  input  wire hkr_pkg::tok_t tok_in,
  output hkr_pkg::tok_t     tok_out,
  output logic [7:0]        key
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      key           <= 8'h00;
      tok_out.valid <= 1'b0;
    end else begin
      if (tok_in.valid && key == 8'h00) begin
        key           <= tok_in.key;
        tok_out.valid <= 1'b0;
      end else begin
        tok_out.valid <= tok_in.valid;
      end
    end
    tok_out.key <= tok_in.key;
  end

endmodule
`default_nettype wire

// ===== sv/utf8_to_hid_key_report_core.sv =====
// utf8_to_hid_key_report_core: keyboard report encoder top, sequencer and key slot chain
// depends on hkr_pkg, hkr_ram, hkr_key_cell
//
// One request at a time; busy stays high until its last result. A key press sends a
// token down the row of six slot cells, one cell a cycle. Character lookup reads the
// table memories one row at a time until one matches: combination rows, then the ASCII
// row if the first byte is below the ASCII count and table size, else UTF-8 rows.
// Loads give no result. Results appear for one cycle on result with result_valid and
// cannot be held off.
`default_nettype none
module utf8_to_hid_key_report_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire hkr_pkg::in_t  cmd,
  output logic               result_valid,
  output hkr_pkg::out_t      result,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRD  = 4'd1;
  localparam logic [3:0] S_CCHK = 4'd2;
  localparam logic [3:0] S_ARD  = 4'd3;
  localparam logic [3:0] S_ACHK = 4'd4;
  localparam logic [3:0] S_URD  = 4'd5;
  localparam logic [3:0] S_UCHK = 4'd6;
  localparam logic [3:0] S_INJ  = 4'd7;
  localparam logic [3:0] S_WAIT = 4'd8;
  localparam logic [3:0] S_REL  = 4'd9;
  localparam logic [3:0] S_MOD  = 4'd10;
  localparam logic [3:0] S_NONE = 4'd11;

  logic [3:0] state;
  logic [7:0] ascii_count;
  logic [7:0] utf8_count;
  logic [5:0] combo_count;
  hkr_pkg::in_t req;
  logic [hkr_pkg::SCAN_W-1:0] idx;
  logic [hkr_pkg::SLOT_CW-1:0] wcnt;
  logic [7:0] held_mods;
  logic [7:0] pkey;
  logic [7:0] pmods;
  logic [15:0] ckey;
  logic [1:0] extra;
  logic combo;
  logic [1:0] cph;
  logic clear;

  logic [15:0] ascii_rd;
  logic [47:0] utf8_rd;
  logic [63:0] combo_rd;
  logic [2:0]  cmatch;
  logic [2:0]  umatch;
  logic [hkr_pkg::SCAN_W-1:0] climit;
  logic [hkr_pkg::SCAN_W-1:0] ulimit;
  logic [31:0] chars;
  logic load_ok;
  logic ascii_hit;

  hkr_pkg::tok_t chain [hkr_pkg::KEY_SLOTS+1];
  logic [7:0] keys [hkr_pkg::KEY_SLOTS];
  logic [7:0] rep [hkr_pkg::REPORT_SLOTS];

  assign busy    = (state != S_IDLE);
  assign load_ok = start && !busy;
  assign chars   = {req.char_byte3, req.char_byte2, req.char_byte1, req.char_byte0};
  assign cmatch  = hkr_pkg::match_len(combo_rd[31:0], chars);
  assign umatch  = hkr_pkg::match_len(utf8_rd[31:0], chars);
  assign climit  = (11'(combo_count) > 11'(hkr_pkg::COMBO_ENTRIES)) ?
                   11'(hkr_pkg::COMBO_ENTRIES) : 11'(combo_count);
  assign ulimit  = (11'(utf8_count) > 11'(hkr_pkg::UTF8_ENTRIES)) ?
                   11'(hkr_pkg::UTF8_ENTRIES) : 11'(utf8_count);
  assign ascii_hit = (req.char_byte0 < ascii_count) &&
                     (11'(req.char_byte0) < 11'(hkr_pkg::ASCII_ENTRIES));

  hkr_ram #(.WIDTH(16), .DEPTH(hkr_pkg::ASCII_ENTRIES)) u_ascii (
    .clk   (clk),
    .we    (load_ok && cmd.func == hkr_pkg::FN_LOAD_ASCII &&
            11'(cmd.entry_index) < 11'(hkr_pkg::ASCII_ENTRIES)),
    .waddr (cmd.entry_index[hkr_pkg::ASCII_AW-1:0]),
    .wdata (cmd.entry_data[15:0]),
    .raddr (req.char_byte0[hkr_pkg::ASCII_AW-1:0]),
    .rdata (ascii_rd)
  );

  hkr_ram #(.WIDTH(48), .DEPTH(hkr_pkg::UTF8_ENTRIES)) u_utf8 (
    .clk   (clk),
    .we    (load_ok && cmd.func == hkr_pkg::FN_LOAD_UTF8 &&
            11'(cmd.entry_index) < 11'(hkr_pkg::UTF8_ENTRIES)),
    .waddr (cmd.entry_index[hkr_pkg::UTF8_AW-1:0]),
    .wdata (cmd.entry_data[47:0]),
    .raddr (idx[hkr_pkg::UTF8_AW-1:0]),
    .rdata (utf8_rd)
  );

  hkr_ram #(.WIDTH(64), .DEPTH(hkr_pkg::COMBO_ENTRIES)) u_combo (
    .clk   (clk),
    .we    (load_ok && cmd.func == hkr_pkg::FN_LOAD_COMBO &&
            11'(cmd.entry_index) < 11'(hkr_pkg::COMBO_ENTRIES)),
    .waddr (cmd.entry_index[hkr_pkg::COMBO_AW-1:0]),
    .wdata (cmd.entry_data),
    .raddr (idx[hkr_pkg::COMBO_AW-1:0]),
    .rdata (combo_rd)
  );

  assign chain[0].valid = (state == S_INJ);
  assign chain[0].key   = pkey;

  for (genvar g = 0; g < hkr_pkg::KEY_SLOTS; g++) begin : g_cell
    hkr_key_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1]),
      .key     (keys[g])
    );
  end

  always_comb begin
    for (int s = 0; s < hkr_pkg::REPORT_SLOTS; s++) begin
      rep[s] = (s < hkr_pkg::KEY_SLOTS) ? keys[s] : 8'h00;
    end
  end

  assign clear = (state == S_REL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ascii_count  <= 8'h00;
      utf8_count   <= 8'h00;
      combo_count  <= 6'h00;
      held_mods    <= 8'h00;
      result_valid <= 1'b0;
      combo        <= 1'b0;
      cph          <= 2'd0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          hkr_pkg::CFG_ASCII_COUNT: ascii_count <= cfg_data;
          hkr_pkg::CFG_UTF8_COUNT:  utf8_count  <= cfg_data;
          hkr_pkg::CFG_COMBO_COUNT: combo_count <= cfg_data[5:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (load_ok) begin
            req   <= cmd;
            extra <= 2'd0;
            combo <= 1'b0;
            idx   <= '0;
            pkey  <= cmd.key_code;
            pmods <= cmd.modifier_bits;
            unique case (cmd.func)
              hkr_pkg::FN_PRESS_CHAR, hkr_pkg::FN_TYPE_CHAR: state <= S_CRD;
              hkr_pkg::FN_RELEASE:   state <= S_REL;
              hkr_pkg::FN_PRESS_KEY: state <= S_INJ;
              hkr_pkg::FN_PRESS_MOD: state <= S_MOD;
              default:               state <= S_IDLE;
            endcase
          end
        end
        S_CRD: begin
          if (idx < climit) begin
            state <= S_CCHK;
          end else begin
            idx   <= '0;
            state <= ascii_hit ? S_ARD : S_URD;
          end
        end
        S_CCHK: begin
          if (cmatch != 3'd0) begin
            extra <= 2'(cmatch - 3'd1);
            combo <= 1'b1;
            cph   <= 2'd0;
            pmods <= combo_rd[39:32];
            pkey  <= combo_rd[47:40];
            ckey  <= combo_rd[63:48];
            state <= S_INJ;
          end else begin
            idx   <= idx + 11'd1;
            state <= S_CRD;
          end
        end
        S_ARD: state <= S_ACHK;
        S_ACHK: begin
          pmods <= ascii_rd[7:0];
          pkey  <= ascii_rd[15:8];
          state <= S_INJ;
        end
        S_URD: begin
          if (idx < ulimit) begin
            state <= S_UCHK;
          end else begin
            state <= (req.func == hkr_pkg::FN_TYPE_CHAR) ? S_REL : S_NONE;
          end
        end
        S_UCHK: begin
          if (umatch != 3'd0) begin
            extra <= 2'(umatch - 3'd1);
            pmods <= utf8_rd[39:32];
            pkey  <= utf8_rd[47:40];
            state <= S_INJ;
          end else begin
            idx   <= idx + 11'd1;
            state <= S_URD;
          end
        end
        S_INJ: begin
          wcnt  <= '0;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (wcnt == hkr_pkg::SLOT_CW'(hkr_pkg::KEY_SLOTS - 1)) begin
            if (!chain[hkr_pkg::KEY_SLOTS].valid) begin
              held_mods                <= held_mods | pmods;
              result_valid             <= 1'b1;
              result.report_valid      <= 1'b1;
              result.report_modifiers  <= held_mods | pmods;
              result.key_slot0         <= rep[0];
              result.key_slot1         <= rep[1];
              result.key_slot2         <= rep[2];
              result.key_slot3         <= rep[3];
              result.key_slot4         <= rep[4];
              result.key_slot5         <= rep[5];
              result.extra_bytes       <= extra;
              result.last              <= !combo && req.func != hkr_pkg::FN_TYPE_CHAR;
            end else if (!combo && req.func != hkr_pkg::FN_TYPE_CHAR) begin
              result_valid            <= 1'b1;
              result                  <= '0;
              result.extra_bytes      <= extra;
              result.last             <= 1'b1;
            end
            if (combo) begin
              cph   <= cph + 2'd1;
              state <= S_REL;
            end else if (req.func == hkr_pkg::FN_TYPE_CHAR) begin
              state <= S_REL;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_REL: begin
          held_mods          <= 8'h00;
          result_valid       <= 1'b1;
          result             <= '0;
          result.report_valid <= 1'b1;
          result.extra_bytes <= extra;
          if (combo && cph == 2'd1) begin
            cph   <= 2'd2;
            pmods <= ckey[7:0];
            pkey  <= ckey[15:8];
            state <= S_INJ;
          end else if (combo) begin
            combo       <= 1'b0;
            result.last <= (req.func != hkr_pkg::FN_TYPE_CHAR);
            state       <= (req.func == hkr_pkg::FN_TYPE_CHAR) ? S_REL : S_IDLE;
          end else begin
            result.last <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_MOD: begin
          held_mods               <= held_mods | req.key_code;
          result_valid            <= 1'b1;
          result.report_valid     <= 1'b1;
          result.report_modifiers <= held_mods | req.key_code;
          result.key_slot0        <= rep[0];
          result.key_slot1        <= rep[1];
          result.key_slot2        <= rep[2];
          result.key_slot3        <= rep[3];
          result.key_slot4        <= rep[4];
          result.key_slot5        <= rep[5];
          result.extra_bytes      <= 2'd0;
          result.last             <= 1'b1;
          state                   <= S_IDLE;
        end
        S_NONE: begin
          result_valid       <= 1'b1;
          result             <= '0;
          result.extra_bytes <= extra;
          result.last        <= 1'b1;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/hkr_checker.sv =====
// hkr_checker: port level checks of the key report encoder, bound to the top level
// depends on hkr_pkg and utf8_to_hid_key_report_core
`default_nettype none
module hkr_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire hkr_pkg::in_t  cmd,
  input wire logic          result_valid,
  input wire hkr_pkg::out_t result
);

  a_result_in_request: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result outside a request");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy) else $error("busy after last result");

  a_count_only_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.report_valid |->
      result.last && result.report_modifiers == 8'h00 && result.key_slot0 == 8'h00)
    else $error("count-only result not empty");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.func == hkr_pkg::FN_LOAD_ASCII ||
      cmd.func == hkr_pkg::FN_LOAD_UTF8 || cmd.func == hkr_pkg::FN_LOAD_COMBO)
      |=> !busy && !result_valid) else $error("load gave a result");

endmodule

bind utf8_to_hid_key_report_core hkr_checker u_hkr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result       (result)
);
`default_nettype wire
